// ===== hw/rtl/hrpm_pkg.sv =====
// Shared constants, register indexes and control structs of the heart rate meter.
// Used by hrpm_ctrl, hrpm_datapath and heart_rate_pulse_meter_unit; no dependencies.
package hrpm_pkg;

  // Beat intervals timed per measurement
  localparam int INTERVALS = 5;

  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 10;
  localparam int THR_W      = 10;
  localparam int MISS_W     = 16;
  localparam int PERIOD_W   = 20;
  localparam int TICK_W     = 8;
  localparam int BEAT_W     = 3;
  localparam int BPM_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Rate numerator: 60 s/min * intervals * 1e6 us/s
  localparam longint RATE_NUM = 64'd60 * INTERVALS * 64'd1000000;
  localparam int NUM_W     = $clog2(RATE_NUM + 1);
  localparam int DEN_W     = PERIOD_W + TICK_W;
  localparam int DSH_W     = DEN_W + BPM_W - 1;
  localparam int SAT_W     = DEN_W + BPM_W;
  localparam int DIV_CNT_W = $clog2(BPM_W);

  localparam logic [NUM_W-1:0]  RATE_NUM_C = NUM_W'(RATE_NUM);
  localparam logic [BPM_W-1:0]  BPM_MAX    = '1;
  localparam logic [BEAT_W-1:0] BEAT_LAST  = BEAT_W'(INTERVALS);
  localparam logic [TICK_W-1:0] TICK_MAX   = '1;

  // Item operation codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd4;

  // Configuration reset values
  localparam logic [THR_W-1:0]    INIT_THR_RST    = 10'd600;
  localparam logic [THR_W-1:0]    THR_FLOOR_RST   = 10'd500;
  localparam logic [THR_W-1:0]    THR_STEP_RST    = 10'd200;
  localparam logic [MISS_W-1:0]   MISS_LIMIT_RST  = 16'd40000;
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 20'd43690;

  typedef struct packed {
    logic step;        // item accepted this cycle
    logic div_init;    // load divider operands
    logic div_step;    // one quotient bit
    logic out_load;    // load output register
    logic out_giveup;  // result is a give-up
  } hrpm_cmd_t;

  typedef struct packed {
    logic rate_ev;     // accepted item finishes a measurement
    logic giveup_ev;   // accepted item gives up
    logic out_free;    // output register can take a result
  } hrpm_sts_t;

endpackage

// ===== hw/rtl/hrpm_ctrl.sv =====
// Controller of the heart rate meter: item acceptance, divider sequencing, delivery.
// Depends on hrpm_pkg.
module hrpm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hrpm_pkg::hrpm_sts_t   sts,
  output hrpm_pkg::hrpm_cmd_t   cmd
);
  import hrpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_DELIVER
  } state_t;

  state_t               state_r;
  logic                 giveup_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.step       = (state_r == S_IDLE) && in_valid;
    cmd.div_init   = (state_r == S_DIV_INIT);
    cmd.div_step   = (state_r == S_DIV);
    cmd.out_load   = (state_r == S_DELIVER) && sts.out_free;
    cmd.out_giveup = giveup_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      giveup_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.step && sts.rate_ev) begin
            giveup_r <= 1'b0;
            state_r  <= S_DIV_INIT;
          end else if (cmd.step && sts.giveup_ev) begin
            giveup_r <= 1'b1;
            state_r  <= S_DELIVER;
          end
        end
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == DIV_CNT_W'(BPM_W - 1)) begin
            state_r <= S_DELIVER;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DELIVER: begin
          // hold until the output register is free
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/hrpm_datapath.sv =====
// Datapath of the heart rate meter: config registers, measurement state,
// restoring divider for the rate and the output register. Depends on hrpm_pkg.
module hrpm_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hrpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hrpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [hrpm_pkg::OP_W-1:0]        in_op,
  input  logic [hrpm_pkg::SAMPLE_W-1:0]    in_sample,
  input  hrpm_pkg::hrpm_cmd_t              cmd,
  output hrpm_pkg::hrpm_sts_t              sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hrpm_pkg::BPM_W-1:0]       out_bpm,
  output logic                             out_status
);
  import hrpm_pkg::*;

  // configuration
  logic [THR_W-1:0]    init_thr_r;
  logic [THR_W-1:0]    floor_r;
  logic [THR_W-1:0]    step_r;
  logic [MISS_W-1:0]   miss_limit_r;
  logic [PERIOD_W-1:0] period_r;

  // measurement state
  logic                active_r, active_nxt;
  logic                pulse_r, pulse_nxt;
  logic [BEAT_W-1:0]   beat_r, beat_nxt;
  logic [MISS_W-1:0]   miss_r, miss_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic                timing_r, timing_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;

  // divider
  logic [DEN_W-1:0]    den_r;
  logic [NUM_W-1:0]    rem_r;
  logic [DSH_W-1:0]    dsh_r;
  logic [BPM_W-1:0]    quo_r;
  logic                sat_r;

  // output register
  logic                out_valid_r;
  logic [BPM_W-1:0]    out_bpm_r;
  logic                out_status_r;

  logic                is_sample, rise, fall, timeout, above_floor;
  logic [MISS_W-1:0]   miss_inc;
  logic [THR_W-1:0]    thr_dropped;
  logic                div_ge;
  logic [DSH_W-1:0]    rem_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_thr_r   <= INIT_THR_RST;
      floor_r      <= THR_FLOOR_RST;
      step_r       <= THR_STEP_RST;
      miss_limit_r <= MISS_LIMIT_RST;
      period_r     <= TICK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_THR:    init_thr_r   <= cfg_wdata[THR_W-1:0];
        REG_THR_FLOOR:   floor_r      <= cfg_wdata[THR_W-1:0];
        REG_THR_STEP:    step_r       <= cfg_wdata[THR_W-1:0];
        REG_MISS_LIMIT:  miss_limit_r <= cfg_wdata[MISS_W-1:0];
        REG_TICK_PERIOD: period_r     <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_sample   = (in_op == OP_SAMPLE) && active_r;
    rise        = (THR_W'(in_sample) > thr_r) && !pulse_r;
    fall        = (THR_W'(in_sample) < thr_r) && pulse_r;
    miss_inc    = miss_r + 1'b1;
    timeout     = miss_inc > miss_limit_r;
    above_floor = thr_r > floor_r;
    thr_dropped = (thr_r > step_r) ? thr_r - step_r : '0;

    sts.rate_ev   = is_sample && rise && (beat_r != '0) && (beat_r >= BEAT_LAST);
    sts.giveup_ev = is_sample && !rise && !fall && timeout && !above_floor;
    sts.out_free  = !out_valid_r || out_ready;

    active_nxt = active_r;
    pulse_nxt  = pulse_r;
    beat_nxt   = beat_r;
    miss_nxt   = miss_r;
    thr_nxt    = thr_r;
    timing_nxt = timing_r;
    tick_nxt   = tick_r;

    case (in_op)
      OP_START: begin
        active_nxt = 1'b1;
        pulse_nxt  = 1'b0;
        beat_nxt   = '0;
        miss_nxt   = '0;
        thr_nxt    = init_thr_r;
        timing_nxt = 1'b0;
        tick_nxt   = '0;
      end
      OP_TICK: begin
        if (timing_r && (tick_r != TICK_MAX)) begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (active_r) begin
          if (rise) begin
            pulse_nxt = 1'b1;
            if (sts.rate_ev) begin
              timing_nxt = 1'b0;
              active_nxt = 1'b0;
              tick_nxt   = '0;
              beat_nxt   = '0;
            end else begin
              if (beat_r == '0) begin
                timing_nxt = 1'b1;
              end
              beat_nxt = beat_r + 1'b1;
            end
          end else if (fall) begin
            pulse_nxt = 1'b0;
            miss_nxt  = '0;
          end else begin
            miss_nxt = miss_inc;
            if (timeout) begin
              if (above_floor) begin
                thr_nxt  = thr_dropped;
                miss_nxt = '0;
              end else begin
                active_nxt = 1'b0;
                timing_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pulse_r  <= 1'b0;
      beat_r   <= '0;
      miss_r   <= '0;
      thr_r    <= '0;
      timing_r <= 1'b0;
      tick_r   <= '0;
    end else if (cmd.step) begin
      active_r <= active_nxt;
      pulse_r  <= pulse_nxt;
      beat_r   <= beat_nxt;
      miss_r   <= miss_nxt;
      thr_r    <= thr_nxt;
      timing_r <= timing_nxt;
      tick_r   <= tick_nxt;
    end
  end

  // Restoring division: the saturation test up front leaves a quotient below 2^BPM_W
  always_comb begin
    rem_ext = DSH_W'(rem_r);
    div_ge  = rem_ext >= dsh_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.step && sts.rate_ev) begin
      den_r <= DEN_W'(period_r * tick_r);
    end
    if (cmd.div_init) begin
      rem_r <= RATE_NUM_C;
      dsh_r <= {den_r, (BPM_W - 1)'(0)};
      sat_r <= SAT_W'(RATE_NUM_C) >= {den_r, BPM_W'(0)};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= NUM_W'(rem_ext - dsh_r);
      end
      quo_r <= {quo_r[BPM_W-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_giveup;
      if (cmd.out_giveup) begin
        out_bpm_r <= '0;
      end else begin
        out_bpm_r <= sat_r ? BPM_MAX : quo_r;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_bpm    = out_bpm_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/heart_rate_pulse_meter_unit.sv =====
// Heart rate pulse meter: start, sample and tick items in, a rate or a give-up result
// out when a measurement ends. A start, a tick or a sample that ends nothing leaves
// the controller idle, and the next item can follow in the cycle after. A sample that
// gives up goes through the update, then the load of the output register. The sample
// that closes a measurement goes through the update with the tick-period product, the
// divider load with the saturation test, the restoring divider, one quotient bit per
// step, and the load of the output register.
// A new item is taken while an earlier result waits at the output; a second result
// waits for the first to be taken. Depends on hrpm_pkg, hrpm_ctrl, hrpm_datapath.
module heart_rate_pulse_meter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hrpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hrpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hrpm_pkg::OP_W-1:0]        in_op,
  input  logic [hrpm_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hrpm_pkg::BPM_W-1:0]       out_bpm,
  output logic                             out_status
);
  import hrpm_pkg::*;

  hrpm_cmd_t cmd;
  hrpm_sts_t sts;

  hrpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrpm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_op),
    .in_sample  (in_sample),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bpm    (out_bpm),
    .out_status (out_status)
  );

endmodule

// ===== test/testbench.sv =====
// Testbench for heart_rate_pulse_meter_unit: a directed table, then random measurements.
// Results are checked against an in-bench predictor of the meter. Depends on hrpm_pkg.
`timescale 1ns / 100ps

module testbench;
  import hrpm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;     // slowest item is the one that closes a measurement
  localparam int ITEM_GOAL   = 1950;
  localparam int RESULT_GOAL = 48;
  localparam int HOLD_CYCLES = 300;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [BPM_W-1:0] bpm;
    logic             status;
  } rate_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    code;    // op or register index
    logic [CFG_DATA_W-1:0]   val;     // sample or register value
    logic                    typed;
    rate_t                   exp;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [BPM_W-1:0]      out_bpm;
  logic                  out_status;

  heart_rate_pulse_meter_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bpm    (out_bpm),
    .out_status (out_status)
  );

  // Register copies and tracked meter state
  logic [THR_W-1:0]    cfg_init;
  logic [THR_W-1:0]    cfg_floor;
  logic [THR_W-1:0]    cfg_step;
  logic [MISS_W-1:0]   cfg_miss;
  logic [PERIOD_W-1:0] cfg_period;

  logic              trk_active;
  logic              trk_pulse;
  logic [BEAT_W-1:0] trk_beats;
  logic [MISS_W-1:0] trk_miss;
  logic [THR_W-1:0]  trk_thr;
  logic              trk_timing;
  logic [TICK_W-1:0] trk_ticks;

  rate_t rate_q[$];
  row_t  rows[$];

  int  fails;
  int  taken;
  int  items_sent;
  int  cycle_cnt;
  bit  tx_busy;
  bit  rx_busy;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Exact rate: 60 s * intervals * 1e6 us over the timed span, saturated
  function automatic logic [BPM_W-1:0] bpm_of(input logic [PERIOD_W-1:0] period,
                                               input logic [TICK_W-1:0] ticks);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    num = 64'd60 * INTERVALS * 64'd1000000;
    den = {44'd0, period} * {56'd0, ticks};
    if (den == 0) return '1;
    q = num / den;
    return (q > 1023) ? '1 : q[BPM_W-1:0];
  endfunction

  task automatic meter_update(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                              output bit hit, output rate_t res);
    hit = 1'b0;
    res = '0;
    case (op)
      OP_START: begin
        trk_active = 1'b1;
        trk_pulse  = 1'b0;
        trk_beats  = '0;
        trk_miss   = '0;
        trk_thr    = cfg_init;
        trk_timing = 1'b0;
        trk_ticks  = '0;
      end
      OP_TICK: begin
        if (trk_timing && trk_ticks != TICK_MAX) trk_ticks = trk_ticks + 1'b1;
      end
      OP_SAMPLE: begin
        if (trk_active) begin
          if (smp > trk_thr && !trk_pulse) begin
            trk_pulse = 1'b1;
            if (trk_beats >= BEAT_LAST) begin
              // closing beat: report the rate and stop
              res.bpm    = bpm_of(cfg_period, trk_ticks);
              res.status = 1'b0;
              hit        = 1'b1;
              trk_timing = 1'b0;
              trk_active = 1'b0;
              trk_ticks  = '0;
              trk_beats  = '0;
            end else begin
              if (trk_beats == 0) trk_timing = 1'b1;
              trk_beats = trk_beats + 1'b1;
            end
          end else if (smp < trk_thr && trk_pulse) begin
            trk_pulse = 1'b0;
            trk_miss  = '0;
          end else begin
            trk_miss = trk_miss + 1'b1;
            if (trk_miss > cfg_miss) begin
              if (trk_thr > cfg_floor) begin
                trk_thr  = (trk_thr > cfg_step) ? trk_thr - cfg_step : '0;
                trk_miss = '0;
              end else begin
                trk_active = 1'b0;
                trk_timing = 1'b0;
                res.bpm    = '0;
                res.status = 1'b1;
                hit        = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT_THR:    cfg_init   = val[THR_W-1:0];
      REG_THR_FLOOR:   cfg_floor  = val[THR_W-1:0];
      REG_THR_STEP:    cfg_step   = val[THR_W-1:0];
      REG_MISS_LIMIT:  cfg_miss   = val[MISS_W-1:0];
      REG_TICK_PERIOD: cfg_period = val[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait out every pending rate, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rate_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic offer(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                       input bit typed, input rate_t typed_res);
    int    gap;
    bit    hit;
    rate_t got;
    gap = tx_busy ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    if (!(op == OP_SPARE || (op == OP_SAMPLE && !trk_active))) items_sent++;
    meter_update(op, smp, hit, got);
    if (typed) rate_q.push_back(typed_res);
    else if (hit) rate_q.push_back(got);
  endtask

  task automatic feed(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp);
    offer(op, smp, 1'b0, '0);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] code,
                         input logic [CFG_DATA_W-1:0] val, input logic typed,
                         input logic [BPM_W-1:0] bpm, input logic status);
    row_t r;
    r.kind       = kind;
    r.code       = code;
    r.val        = val;
    r.typed      = typed;
    r.exp.bpm    = bpm;
    r.exp.status = status;
    rows.push_back(r);
  endtask

  function automatic logic [CFG_DATA_W-1:0] spread(input int hi);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_W'(hi);
      default: return CFG_DATA_W'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic configure(input int ph);
    logic [CFG_DATA_W-1:0] thr0;
    logic [CFG_DATA_W-1:0] flr;
    logic [CFG_DATA_W-1:0] stp;
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] per;
    if (ph == 0) begin
      thr0 = '0; flr = '0; stp = '0; lim = '0; per = '0;
    end else if (ph == 1) begin
      thr0 = 1023; flr = 1023; stp = 1023; lim = 65535; per = 20'hFFFFF;
    end else begin
      thr0 = spread(1023);
      flr  = spread(1023);
      stp  = spread(1023);
      lim  = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 12))
                                         : spread(65535);
      per  = ($urandom_range(0, 2) == 0) ? spread(20'hFFFFF)
                                         : CFG_DATA_W'($urandom_range(2000, 60000));
    end
    write_reg(REG_INIT_THR, thr0);
    write_reg(REG_THR_FLOOR, flr);
    write_reg(REG_THR_STEP, stp);
    write_reg(REG_MISS_LIMIT, lim);
    write_reg(REG_TICK_PERIOD, per);
  endtask

  // One start and up to six beats: rise, some flat samples, ticks, fall
  task automatic measure();
    int tick_cap;
    int n;
    feed(OP_START, SAMPLE_W'($urandom_range(0, 1023)));
    tick_cap = ($urandom_range(0, 5) == 0) ? 70 : 12;
    for (int b = 0; b < 6 && trk_active; b++) begin
      if ($urandom_range(0, 20) == 0) feed(OP_START, SAMPLE_W'($urandom_range(0, 1023)));
      if (trk_thr < 1023) feed(OP_SAMPLE, SAMPLE_W'($urandom_range(trk_thr + 1, 1023)));
      else feed(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
      if (!trk_active) break;
      n = $urandom_range(0, 3);
      repeat (n) begin
        if (trk_pulse) feed(OP_SAMPLE, SAMPLE_W'($urandom_range(trk_thr, 1023)));
        else feed(OP_SAMPLE, SAMPLE_W'($urandom_range(0, trk_thr)));
      end
      n = $urandom_range(0, tick_cap);
      repeat (n) feed(OP_TICK, SAMPLE_W'($urandom_range(0, 1023)));
      if ($urandom_range(0, 15) == 0)
        feed(OP_W'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)));
      if (trk_thr > 0) feed(OP_SAMPLE, SAMPLE_W'($urandom_range(0, trk_thr - 1)));
      else feed(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
    end
  endtask

  // Result side
  task automatic take_result(input rate_t got);
    rate_t want;
    taken++;
    if (rate_q.size() == 0) begin
      if (fails < 10) $display("unexpected rate: bpm %0d status %0d", got.bpm, got.status);
      fails++;
    end else begin
      want = rate_q.pop_front();
      if (got.bpm !== want.bpm || got.status !== want.status) begin
        if (fails < 10)
          $display("rate mismatch: expected bpm %0d status %0d, got bpm %0d status %0d",
                   want.bpm, want.status, got.bpm, got.status);
        fails++;
      end
    end
  endtask

  initial begin
    int stall;
    int hold_left;
    rate_t got;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for results to back up into the input
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
      end
      stall = rx_busy ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.bpm    = out_bpm;
      got.status = out_status;
      take_result(got);
      @(negedge clk);
    end
  end

  initial begin
    int    ph;
    int    target;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_op      = OP_START;
    in_sample  = '0;
    fails      = 0;
    taken      = 0;
    items_sent = 0;
    tx_busy    = 1'b1;
    rx_busy    = 1'b1;
    hold_req   = 1'b0;

    cfg_init   = INIT_THR_RST;
    cfg_floor  = THR_FLOOR_RST;
    cfg_step   = THR_STEP_RST;
    cfg_miss   = MISS_LIMIT_RST;
    cfg_period = TICK_PERIOD_RST;
    trk_active = 1'b0;
    trk_pulse  = 1'b0;
    trk_beats  = '0;
    trk_miss   = '0;
    trk_thr    = '0;
    trk_timing = 1'b0;
    trk_ticks  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    //       kind      op / reg                sample / value typed bpm  status
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0); // idle sample
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SPARE),  1023,          0,    0,   0); // unused op
    add_row(ROW_ITEM, CFG_IDX_W'(OP_TICK),   0,             0,    0,   0); // tick while idle
    add_row(ROW_ITEM, CFG_IDX_W'(OP_START),  0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0); // first beat
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 600,           0,    0,   0); // at threshold
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 1023,          1, 1023,   0); // no ticks
    add_row(ROW_CFG,  REG_MISS_LIMIT,        0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_START),  0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 600,           0,    0,   0); // step down
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 400,           1,    0,   1); // below floor
    add_row(ROW_CFG,  REG_THR_STEP,          1023,          0,    0,   0);
    add_row(ROW_CFG,  REG_THR_FLOOR,         0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_START),  0,             0,    0,   0);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 600,           0,    0,   0); // step clamps
    add_row(ROW_ITEM, CFG_IDX_W'(OP_SAMPLE), 0,             1,    0,   1);
    add_row(ROW_ITEM, CFG_IDX_W'(OP_TICK),   1023,          0,    0,   0);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].code, rows[i].val);
      end else begin
        offer(rows[i].code[OP_W-1:0], rows[i].val[SAMPLE_W-1:0], rows[i].typed, rows[i].exp);
      end
    end

    for (ph = 0; (items_sent < ITEM_GOAL || taken < RESULT_GOAL) && ph < 80; ph++) begin
      wait_idle();
      tx_busy = ($urandom_range(0, 3) != 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      if (ph == 3) begin
        // every start and sample pair gives up at once; results back up
        write_reg(REG_INIT_THR, 1023);
        write_reg(REG_THR_FLOOR, 1023);
        write_reg(REG_MISS_LIMIT, 0);
        tx_busy  = 1'b0;
        hold_req = 1'b1;
        repeat (30) begin
          feed(OP_START, SAMPLE_W'($urandom_range(0, 1023)));
          feed(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
        end
      end else begin
        configure(ph);
        target = items_sent + 200;
        while (items_sent < target) begin
          if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(5, 20))
              feed(OP_W'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)));
          end else begin
            measure();
          end
        end
      end
    end

    wait_idle();
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
